[hw/rtl/nci_pkg.sv]
// ----------------------------------------------------------------------------
// nci_pkg
// Shared types and codes for the nearest-centre quadratic interpolator.
// ----------------------------------------------------------------------------
package nci_pkg;

	localparam int DATA_W  = 32;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 11;

	// action codes
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_APP_RND,
		S_APP_WR,
		S_Q_LAST,
		S_Q_FIRST,
		S_Q_BIS,
		S_Q_PICK,
		S_Q_DIFF,
		S_Q_M1,
		S_Q_M2,
		S_Q_M3,
		S_Q_M4,
		S_Q_M5,
		S_Q_SUM,
		S_FINISH
	} nci_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_RES_OK,
		OP_CLEAR,
		OP_REJECT,
		OP_EMPTY,
		OP_APP_MUL,
		OP_APP_RND,
		OP_APP_WR,
		OP_RD_LAST,
		OP_CHK_LAST,
		OP_CHK_FIRST,
		OP_BISECT,
		OP_PICK,
		OP_DIFF,
		OP_MUL1,
		OP_MUL2,
		OP_MUL3,
		OP_MUL4,
		OP_MUL5,
		OP_SUM
	} nci_op_t;

	typedef struct packed {
		nci_op_t op;
		logic    out_load;
	} nci_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       full;
		logic       empty;
		logic       hit_last;
		logic       hit_first;
		logic       bis_done;
	} nci_sts_t;

endpackage

[hw/rtl/nci_ctrl.sv]
// ----------------------------------------------------------------------------
// nci_ctrl
// Sequencer for the interpolator: walks each item through its datapath steps.
// ----------------------------------------------------------------------------
module nci_ctrl import nci_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  nci_sts_t sts,
	output nci_cmd_t cmd
);

	nci_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.action)
					ACT_CLEAR: begin
						cmd.op  = OP_CLEAR;
						state_d = S_FINISH;
					end
					ACT_APPEND: begin
						if (sts.full) begin
							cmd.op  = OP_REJECT;
							state_d = S_FINISH;
						end else begin
							cmd.op  = OP_APP_MUL;
							state_d = S_APP_RND;
						end
					end
					ACT_QUERY: begin
						if (sts.empty) begin
							cmd.op  = OP_EMPTY;
							state_d = S_FINISH;
						end else begin
							cmd.op  = OP_RD_LAST;
							state_d = S_Q_LAST;
						end
					end
					default: begin
						cmd.op  = OP_RES_OK;
						state_d = S_FINISH;
					end
				endcase
			end
			S_APP_RND: begin
				cmd.op  = OP_APP_RND;
				state_d = S_APP_WR;
			end
			S_APP_WR: begin
				cmd.op  = OP_APP_WR;
				state_d = S_FINISH;
			end
			S_Q_LAST: begin
				cmd.op  = OP_CHK_LAST;
				state_d = sts.hit_last ? S_Q_DIFF : S_Q_FIRST;
			end
			S_Q_FIRST: begin
				cmd.op = OP_CHK_FIRST;
				if (sts.hit_first) begin
					state_d = S_Q_DIFF;
				end else if (sts.bis_done) begin
					state_d = S_Q_PICK;
				end else begin
					state_d = S_Q_BIS;
				end
			end
			S_Q_BIS: begin
				cmd.op  = OP_BISECT;
				state_d = sts.bis_done ? S_Q_PICK : S_Q_BIS;
			end
			S_Q_PICK: begin
				cmd.op  = OP_PICK;
				state_d = S_Q_DIFF;
			end
			S_Q_DIFF: begin
				cmd.op  = OP_DIFF;
				state_d = S_Q_M1;
			end
			S_Q_M1: begin
				cmd.op  = OP_MUL1;
				state_d = S_Q_M2;
			end
			S_Q_M2: begin
				cmd.op  = OP_MUL2;
				state_d = S_Q_M3;
			end
			S_Q_M3: begin
				cmd.op  = OP_MUL3;
				state_d = S_Q_M4;
			end
			S_Q_M4: begin
				cmd.op  = OP_MUL4;
				state_d = S_Q_M5;
			end
			S_Q_M5: begin
				cmd.op  = OP_MUL5;
				state_d = S_Q_SUM;
			end
			S_Q_SUM: begin
				cmd.op  = OP_SUM;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

[hw/rtl/nci_dp.sv]
// ----------------------------------------------------------------------------
// nci_dp
// Datapath: table memories, bisection registers, shared multiplier, rounding.
// ----------------------------------------------------------------------------
module nci_dp import nci_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int FRAC_BITS   = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nci_cmd_t                   cmd,
	output nci_sts_t                   sts,
	input  logic [1:0]                 action,
	input  logic signed [DATA_W-1:0]   centre,
	input  logic signed [DATA_W-1:0]   value_at_centre,
	input  logic signed [DATA_W-1:0]   slope,
	input  logic signed [DATA_W-1:0]   slope_change,
	input  logic signed [DATA_W-1:0]   query_point,
	output logic [1:0]                 status,
	output logic [INDEX_W-1:0]         nearest_index,
	output logic signed [DATA_W-1:0]   result_value,
	output logic [COUNT_W-1:0]         entry_count
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// round half up at bit s, then clamp to 32 bits
	function automatic logic signed [DATA_W-1:0] rnd_sat(
		input logic signed [2*DATA_W-1:0] p,
		input int unsigned s
	);
		logic signed [2*DATA_W-1:0] r;
		r = (p + (64'sd1 <<< (s - 1))) >>> s;
		if (r > 64'sh0000_0000_7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end else if (r < 64'shFFFF_FFFF_8000_0000) begin
			return 32'sh8000_0000;
		end
		return r[DATA_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
		if (v[DATA_W] != v[DATA_W-1]) begin
			return v[DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return v[DATA_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] v);
		if ((v[DATA_W+1] != v[DATA_W]) || (v[DATA_W] != v[DATA_W-1])) begin
			return v[DATA_W+1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return v[DATA_W-1:0];
	endfunction

	// table storage
	logic [DATA_W-1:0]   centre_mem [TABLE_DEPTH];
	logic [3*DATA_W-1:0] coef_mem   [TABLE_DEPTH];

	// latched item
	logic [1:0]               action_q;
	logic signed [DATA_W-1:0] centre_q, vac_q, slope_q, chg_q, q_q;

	logic [CW-1:0] count_q;
	logic [IW-1:0] low_q, high_q, mid_q, k_q;
	logic [IW-1:0] low_d, high_d, mid_d, k_d, last, c_addr;
	logic [IW:0]   mid_sum;
	logic signed [DATA_W-1:0] c_rd_q, clow_q, chigh_q, ck_q, ck_d;
	logic [3*DATA_W-1:0]      cf_rd_q;
	logic signed [DATA_W-1:0] coef_c0, coef_c1, coef_c2;
	logic signed [DATA_W-1:0] d_q, t1_q, rs_q, rs_d;
	logic signed [2*DATA_W-1:0] prod_q;
	logic signed [DATA_W-1:0] mul_a, mul_b;
	logic                     mul_en, rs_en;
	logic signed [DATA_W:0]   dist_lo, dist_hi, diff;
	logic signed [DATA_W+1:0] sum;
	logic                     pick_low, hit_last, hit_first, le_q, wr_en;

	logic [1:0]               res_status_q;
	logic [IW-1:0]            res_index_q;
	logic signed [DATA_W-1:0] res_value_q;

	assign last     = IW'(count_q - CW'(1));
	assign coef_c0  = cf_rd_q[3*DATA_W-1:2*DATA_W];
	assign coef_c1  = cf_rd_q[2*DATA_W-1:DATA_W];
	assign coef_c2  = cf_rd_q[DATA_W-1:0];
	assign hit_last  = (q_q >= c_rd_q);
	assign hit_first = (q_q <= c_rd_q);
	assign le_q      = (c_rd_q <= q_q);
	assign dist_lo  = {q_q[DATA_W-1], q_q} - {clow_q[DATA_W-1], clow_q};
	assign dist_hi  = {chigh_q[DATA_W-1], chigh_q} - {q_q[DATA_W-1], q_q};
	assign pick_low = (dist_lo < dist_hi);
	assign diff     = {q_q[DATA_W-1], q_q} - {ck_q[DATA_W-1], ck_q};
	assign sum      = {{2{coef_c0[DATA_W-1]}}, coef_c0} + {{2{t1_q[DATA_W-1]}}, t1_q}
	                + {{2{rs_q[DATA_W-1]}}, rs_q};
	assign wr_en    = (cmd.op == OP_APP_WR);

	// bisection bounds and entry choice
	always_comb begin
		low_d  = low_q;
		high_d = high_q;
		k_d    = k_q;
		ck_d   = ck_q;
		c_addr = '0;
		case (cmd.op)
			OP_RD_LAST: c_addr = last;
			OP_CHK_LAST: begin
				if (hit_last) begin
					k_d  = last;
					ck_d = c_rd_q;
				end
			end
			OP_CHK_FIRST: begin
				if (hit_first) begin
					k_d  = '0;
					ck_d = c_rd_q;
				end
				low_d  = '0;
				high_d = last;
			end
			OP_BISECT: begin
				if (le_q) begin
					low_d = mid_q;
				end else begin
					high_d = mid_q;
				end
			end
			OP_PICK: begin
				k_d  = pick_low ? low_q : high_q;
				ck_d = pick_low ? clow_q : chigh_q;
			end
			default: ;
		endcase
		mid_sum = {1'b0, low_d} + {1'b0, high_d};
		mid_d   = mid_sum[IW:1];
		if (cmd.op == OP_CHK_FIRST || cmd.op == OP_BISECT) begin
			c_addr = mid_d;
		end
	end

	// multiplier operand and rounding selects
	always_comb begin
		mul_a  = coef_c1;
		mul_b  = d_q;
		mul_en = 1'b0;
		rs_en  = 1'b0;
		rs_d   = rnd_sat(prod_q, FRAC_BITS);
		case (cmd.op)
			OP_APP_MUL: begin
				mul_a  = chg_q;
				mul_b  = slope_q;
				mul_en = 1'b1;
			end
			OP_APP_RND: begin
				rs_d  = rnd_sat(prod_q, FRAC_BITS + 1);
				rs_en = 1'b1;
			end
			OP_MUL1: mul_en = 1'b1;
			OP_MUL2: begin
				mul_a  = coef_c2;
				mul_en = 1'b1;
				rs_en  = 1'b1;
			end
			OP_MUL3: rs_en = 1'b1;
			OP_MUL4: begin
				mul_a  = rs_q;
				mul_en = 1'b1;
			end
			OP_MUL5: rs_en = 1'b1;
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (wr_en) begin
			centre_mem[IW'(count_q)] <= centre_q;
		end
		c_rd_q <= centre_mem[c_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			coef_mem[IW'(count_q)] <= {vac_q, slope_q, rs_q};
		end
		cf_rd_q <= coef_mem[k_d];
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.op == OP_CLEAR) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CW'(1);
		end
	end

	// payload, bisection, product and result registers
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			action_q <= action;
			centre_q <= centre;
			vac_q    <= value_at_centre;
			slope_q  <= slope;
			chg_q    <= slope_change;
			q_q      <= query_point;
		end
		low_q  <= low_d;
		high_q <= high_d;
		mid_q  <= mid_d;
		k_q    <= k_d;
		ck_q   <= ck_d;
		case (cmd.op)
			OP_CHK_LAST:  chigh_q <= c_rd_q;
			OP_CHK_FIRST: clow_q  <= c_rd_q;
			OP_BISECT: begin
				if (le_q) begin
					clow_q <= c_rd_q;
				end else begin
					chigh_q <= c_rd_q;
				end
			end
			default: ;
		endcase
		if (cmd.op == OP_DIFF) begin
			d_q <= sat33(diff);
		end
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (rs_en) begin
			rs_q <= rs_d;
		end
		if (cmd.op == OP_MUL3) begin
			t1_q <= rs_q;
		end
		case (cmd.op) inside
			OP_CLEAR, OP_RES_OK, OP_APP_WR: begin
				res_status_q <= ST_OK;
				res_index_q  <= '0;
				res_value_q  <= '0;
			end
			OP_REJECT: begin
				res_status_q <= ST_FULL;
				res_index_q  <= '0;
				res_value_q  <= '0;
			end
			OP_EMPTY: begin
				res_status_q <= ST_EMPTY;
				res_index_q  <= '0;
				res_value_q  <= '0;
			end
			OP_SUM: begin
				res_status_q <= ST_OK;
				res_index_q  <= k_q;
				res_value_q  <= sat34(sum);
			end
			default: ;
		endcase
		if (cmd.out_load) begin
			status        <= res_status_q;
			nearest_index <= INDEX_W'(res_index_q);
			result_value  <= res_value_q;
			entry_count   <= COUNT_W'(count_q);
		end
	end

	assign sts.action    = action_q;
	assign sts.full      = (count_q == CW'(TABLE_DEPTH));
	assign sts.empty     = (count_q == '0);
	assign sts.hit_last  = hit_last;
	assign sts.hit_first = hit_first;
	assign sts.bis_done  = ((high_d - low_d) <= IW'(1));

endmodule

[hw/rtl/nearest_centre_quadratic_interp.sv]
// ----------------------------------------------------------------------------
// nearest_centre_quadratic_interp
// Table of quadratic Taylor interpolants with nearest-centre lookup.
// ----------------------------------------------------------------------------
// The block keeps up to TABLE_DEPTH entries, each a centre and coefficients
// c0, c1, c2 in signed fixed point with FRAC_BITS fraction bits (Q8.24 by
// default). An append writes the next entry (c2 is half of slope_change times
// slope, rounded half up and saturated); appends must come in ascending centre
// order for the lookup to make sense, and a full table refuses them with
// status 2. A query clamps to the first or last entry, otherwise bisects the
// centres and takes the nearer neighbour (the higher one on a tie), then
// returns c0 + c1*d + c2*d*d with every product rounded and saturated; a query
// of an empty table returns status 1. A clear empties the table in one step.
// Every item gives exactly one result transfer. Items are worked one at a
// time; the length of a query is set by one centre memory read per bisection
// step and a single shared 32x32 multiplier used three times. A finished
// result sits in an output register, so the next item is accepted while that
// result waits to be taken. The table memories have no reset; only entries
// below the count are ever read.
module nearest_centre_quadratic_interp import nci_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int FRAC_BITS   = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input item channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               action,
	input  logic signed [DATA_W-1:0] centre,
	input  logic signed [DATA_W-1:0] value_at_centre,
	input  logic signed [DATA_W-1:0] slope,
	input  logic signed [DATA_W-1:0] slope_change,
	input  logic signed [DATA_W-1:0] query_point,
	// result channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic [INDEX_W-1:0]       nearest_index,
	output logic signed [DATA_W-1:0] result_value,
	output logic [COUNT_W-1:0]       entry_count
);

	// command and status between sequencer and datapath
	nci_cmd_t cmd;
	nci_sts_t sts;

	// sequencer: owns the handshakes and the step order of each item
	nci_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: table memories, bisection bounds, multiplier, result register
	nci_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.action          (action),
		.centre          (centre),
		.value_at_centre (value_at_centre),
		.slope           (slope),
		.slope_change    (slope_change),
		.query_point     (query_point),
		.status          (status),
		.nearest_index   (nearest_index),
		.result_value    (result_value),
		.entry_count     (entry_count)
	);

	// one item in flight: input is closed in the cycle after a transfer in
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in flight");

	// an empty-table query result must report an empty table
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> entry_count == '0 && result_value == '0)
		else $error("empty status with nonzero count or value");

	// a refused append must report a full table
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == COUNT_W'(TABLE_DEPTH))
		else $error("full status while table not full");

	// a new result is only loaded after an item went in
	a_load_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !in_ready)
		else $error("result loaded while idle");

endmodule

[dv/tb_nearest_centre_quadratic_interp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_centre_quadratic_interp
// Self-checking bench for the nearest-centre quadratic interpolator: an
// in-bench table model predicts each result, a queue-fed driver sends
// clear, append, query and unused-action transfers, and a monitor checks every result.
// ----------------------------------------------------------------------------
module tb_nearest_centre_quadratic_interp;
	import nci_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int FRAC_BITS   = 24;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef logic signed [DATA_W-1:0] q_t;

	localparam q_t QMAX  = 32'sh7FFF_FFFF;
	localparam q_t QMIN  = 32'sh8000_0000;
	localparam q_t UNITY = q_t'(longint'(1) << FRAC_BITS);
	// centre spacing that spreads a full table over the whole signed range
	localparam longint FULL_SPACING = 64'sd4294967296 / TABLE_DEPTH;

	typedef struct {
		logic [1:0] act;
		q_t         ctr;
		q_t         c_val;
		q_t         c_slope;
		q_t         c_change;
		q_t         qpt;
	} interp_item_t;

	typedef struct {
		logic [1:0]         st;
		logic [INDEX_W-1:0] idx;
		q_t                 val;
		logic [COUNT_W-1:0] cnt;
	} interp_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         action = ACT_CLEAR;
	q_t                 centre = '0;
	q_t                 value_at_centre = '0;
	q_t                 slope = '0;
	q_t                 slope_change = '0;
	q_t                 query_point = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic [INDEX_W-1:0] nearest_index;
	q_t                 result_value;
	logic [COUNT_W-1:0] entry_count;

	nearest_centre_quadratic_interp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.FRAC_BITS  (FRAC_BITS)
	) dut (.*);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// table model: its own copy of the entries and the entry count
	// ------------------------------------------------------------------
	q_t          centre_tab [TABLE_DEPTH];
	q_t          c0_tab [TABLE_DEPTH];
	q_t          c1_tab [TABLE_DEPTH];
	q_t          c2_tab [TABLE_DEPTH];
	int unsigned held_entries = 0;

	function automatic q_t sat_q(longint v);
		if (v > longint'(QMAX)) return QMAX;
		if (v < longint'(QMIN)) return QMIN;
		return q_t'(v);
	endfunction

	// exact product, round half up at bit s, then saturate
	function automatic q_t mul_q(q_t a, q_t b, int unsigned s);
		longint p;
		p = longint'(a) * longint'(b);
		p = p + (longint'(1) << (s - 1));
		return sat_q(p >>> s);
	endfunction

	// clamp to the ends, else bisect; a tie goes to the higher entry
	function automatic int unsigned nearest_entry(q_t q);
		int unsigned last, lo, hi, mid;
		last = held_entries - 1;
		if (q >= centre_tab[last]) return last;
		if (q <= centre_tab[0]) return 0;
		lo = 0;
		hi = last;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (centre_tab[mid] <= q) lo = mid;
			else hi = mid;
		end
		if (longint'(q) - centre_tab[lo] < longint'(centre_tab[hi]) - q) return lo;
		return hi;
	endfunction

	// advance the table model by one item and return the result it gives
	function automatic interp_result_t interp_step(interp_item_t it);
		interp_result_t r;
		int unsigned k;
		q_t dq, t1, t2;
		r.st  = ST_OK;
		r.idx = '0;
		r.val = '0;
		case (it.act)
			ACT_CLEAR: begin
				held_entries = 0;
			end
			ACT_APPEND: begin
				if (held_entries >= TABLE_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					centre_tab[held_entries] = it.ctr;
					c0_tab[held_entries] = it.c_val;
					c1_tab[held_entries] = it.c_slope;
					c2_tab[held_entries] = mul_q(it.c_change, it.c_slope, FRAC_BITS + 1);
					held_entries++;
				end
			end
			ACT_QUERY: begin
				if (held_entries == 0) begin
					r.st = ST_EMPTY;
				end else begin
					k  = nearest_entry(it.qpt);
					dq = sat_q(longint'(it.qpt) - centre_tab[k]);
					t1 = mul_q(c1_tab[k], dq, FRAC_BITS);
					t2 = mul_q(mul_q(c2_tab[k], dq, FRAC_BITS), dq, FRAC_BITS);
					r.idx = k[INDEX_W-1:0];
					r.val = sat_q(longint'(c0_tab[k]) + t1 + t2);
				end
			end
			default: ;
		endcase
		r.cnt = held_entries[COUNT_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus store and helpers
	// ------------------------------------------------------------------
	interp_item_t   items_to_send [$];
	interp_result_t answers_due [$];
	int             built_centres [$];	// centres of the table being built
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	int             mismatch_count = 0;

	// every field random; the block ignores the ones the action does not use
	function automatic interp_item_t random_item(logic [1:0] a);
		interp_item_t it;
		it.act      = a;
		it.ctr      = $urandom();
		it.c_val    = $urandom();
		it.c_slope  = $urandom();
		it.c_change = $urandom();
		it.qpt      = $urandom();
		return it;
	endfunction

	// half full range, half small values of either sign
	function automatic q_t rand_coef();
		if ($urandom_range(1)) return q_t'($urandom());
		return q_t'($urandom()) >>> $urandom_range(4, 12);
	endfunction

	task automatic push_op(logic [1:0] a);
		items_to_send.insert(items_to_send.size(), random_item(a));
	endtask

	task automatic push_append(q_t c, q_t v, q_t s, q_t sc);
		interp_item_t it;
		it = random_item(ACT_APPEND);
		it.ctr      = c;
		it.c_val    = v;
		it.c_slope  = s;
		it.c_change = sc;
		items_to_send.insert(items_to_send.size(), it);
	endtask

	task automatic push_query(q_t q);
		interp_item_t it;
		it = random_item(ACT_QUERY);
		it.qpt = q;
		items_to_send.insert(items_to_send.size(), it);
	endtask

	// clear, then append n entries in ascending centre order
	task automatic queue_table(int n);
		longint c;
		int step_lg;
		built_centres.delete();
		push_op(ACT_CLEAR);
		if ($urandom_range(1)) begin
			// spread over the whole range
			repeat (n) built_centres.insert(built_centres.size(), int'($urandom()));
			built_centres.sort();
		end else begin
			// packed together, equal centres allowed
			c = longint'(q_t'($urandom())) >>> $urandom_range(0, 8);
			step_lg = $urandom_range(2, 26);
			repeat (n) begin
				built_centres.insert(built_centres.size(), int'(sat_q(c)));
				c = c + longint'($urandom_range(0, 1 << step_lg));
			end
		end
		foreach (built_centres[i])
			push_append(built_centres[i], rand_coef(), rand_coef(), rand_coef());
	endtask

	// queries aimed at the centres just built: on them, near them, at ties,
	// past the ends, or anywhere
	task automatic queue_queries(int m);
		int i, last;
		longint mid2;
		q_t q;
		repeat (m) begin
			last = built_centres.size() - 1;
			i = (last > 0) ? $urandom_range(last) : 0;
			q = $urandom();
			if (last >= 0) begin
				case ($urandom_range(5))
					0: q = built_centres[i];
					1: q = sat_q(longint'(built_centres[i])
						+ longint'($urandom_range(0, 1 << 23)) - (1 << 22));
					2: if (i < last) begin
						mid2 = (longint'(built_centres[i]) + built_centres[i + 1]) >>> 1;
						q = sat_q(mid2 + int'($urandom_range(2)) - 1);
					end
					3: q = sat_q(longint'(built_centres[0]) - longint'($urandom_range(0, 1 << 25)));
					4: q = sat_q(longint'(built_centres[last]) + longint'($urandom_range(0, 1 << 25)));
					default: ;
				endcase
			end
			push_query(q);
		end
	endtask

	// mostly build-then-query sequences, the rest stray items
	task automatic queue_session(int n);
		int start;
		start = items_to_send.size();
		while (items_to_send.size() - start < n) begin
			if ($urandom_range(99) < 80) begin
				queue_table(($urandom_range(3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40));
				queue_queries($urandom_range(3, 12));
				if ($urandom_range(9) == 0) begin
					// centre out of order, then look again
					push_append($urandom(), rand_coef(), rand_coef(), rand_coef());
					queue_queries(3);
				end
			end else begin
				push_op(2'($urandom_range(3)));
			end
		end
	endtask

	// fill every entry, try two more appends, then query the full table
	task automatic queue_full_table();
		built_centres.delete();
		push_op(ACT_CLEAR);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			built_centres.insert(built_centres.size(),
				int'(longint'(QMIN) + longint'(i) * FULL_SPACING
				+ longint'($urandom_range(0, 32'(FULL_SPACING - 1)))));
			push_append(built_centres[i], rand_coef(), rand_coef(), rand_coef());
		end
		repeat (2) push_append($urandom(), rand_coef(), rand_coef(), rand_coef());
		queue_queries(40);
	endtask

	task automatic wait_drained();
		while (items_to_send.size() != 0 || in_valid || answers_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// driver: present the next item once the previous one has transferred
	// ------------------------------------------------------------------
	interp_item_t on_wire;

	always @(posedge clk) begin
		if (arst_n) begin
			// an item transferred at this edge: predict its result
			if (in_valid && in_ready)
				answers_due.insert(answers_due.size(), interp_step(on_wire));
			// valid only drops or moves on after a transfer
			if (!in_valid || in_ready) begin
				if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_wire = items_to_send.pop_front();
					action          <= on_wire.act;
					centre          <= on_wire.ctr;
					value_at_centre <= on_wire.c_val;
					slope           <= on_wire.c_slope;
					slope_change    <= on_wire.c_change;
					query_point     <= on_wire.qpt;
					in_valid        <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: check each result transfer against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		interp_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					report_mismatch("result with none pending, status", status, 0);
				end else begin
					want = answers_due.pop_front();
					if (status !== want.st)
						report_mismatch("status", status, want.st);
					if (nearest_index !== want.idx)
						report_mismatch("nearest_index", nearest_index, want.idx);
					if (result_value !== want.val)
						report_mismatch("result_value", result_value, want.val);
					if (entry_count !== want.cnt)
						report_mismatch("entry_count", entry_count, want.cnt);
				end
			end
			// random back-pressure on the result side
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: too long with no transfer on either side
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, no idling
		send_idle_pct = 0;
		recv_stall_pct = 0;
		push_query(q_t'(0));                       // query of an empty table
		push_op(ACT_UNUSED);                       // unused action on empty table
		push_op(ACT_CLEAR);
		push_append(QMIN, QMAX, QMIN, QMIN);       // c2 saturates high
		push_append(q_t'(0), q_t'(0), UNITY, UNITY);
		push_append(2 * UNITY, UNITY, -UNITY, QMAX);
		push_append(QMAX, QMIN, QMAX, QMIN);       // c2 saturates low
		push_query(QMIN);                          // at the first centre
		push_query(QMAX);                          // at the last centre
		push_query(UNITY);                         // exact tie, higher entry wins
		push_query(UNITY - 1);                     // just below the tie
		push_query(q_t'(-1));
		push_query(32'sh4000_0000);                // large d, saturated terms
		push_query(q_t'(-(longint'(1) << 30)));    // tie on the negative side
		push_op(ACT_UNUSED);                       // unused action with entries held
		push_op(ACT_CLEAR);
		push_query(q_t'(5));                       // empty again after clear
		push_append(QMIN, UNITY, QMAX, QMAX);      // single entry
		push_query(QMAX);                          // d saturates high
		push_query(QMIN);
		push_op(ACT_CLEAR);
		push_append(QMAX, -UNITY, QMIN, q_t'(1 << 20));
		push_query(QMIN);                          // d saturates low
		push_append(q_t'(0), UNITY, UNITY, UNITY); // out of order append
		push_query(q_t'(1 << 20));
		queue_session(100);
		wait_drained();

		// sender idle most of the time
		send_idle_pct = 64;
		recv_stall_pct = 0;
		queue_session(125);
		wait_drained();

		// receiver stalling most of the time
		send_idle_pct = 0;
		recv_stall_pct = 64;
		queue_session(125);
		wait_drained();

		// both sides idling, plus a full table
		send_idle_pct = 26;
		recv_stall_pct = 26;
		queue_session(125);
		queue_full_table();
		wait_drained();

		// let any stray result show up
		repeat (40) @(negedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
